/* sv/ptd_pkg.sv */
package ptd_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_A_X = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_A_Y = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_B_X = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_B_Y = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_C_X = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_C_Y = 3'd5;

    typedef struct packed {
        logic valid;
        logic use_div;
    } t_sel_ctl;

endpackage

/* sv/point_triangle_distance.sv */
// point to triangle distance, 2d, signed fixed point
// configuration: write i_cfg_data to register i_cfg_addr while i_cfg_we is high
//   0 a_x, 1 a_y, 2 b_x, 3 b_y, 4 c_x, 5 c_y; other addresses are ignored
//   write only while no item is in flight
// input: an item (i_point_x, i_point_y) is taken at a rising edge with i_start
//   high and o_busy low; o_busy stays low, so one item per cycle is taken
// output: o_done is high for one cycle with o_distance_out, the distance
//   truncated and saturated, in the same fraction format as the coordinates
// pipeline: the restoring divider, one quotient bit per stage, and the
//   square root, one root bit per stage, follow the front end and selection
// throughput: one item per cycle, results in order of acceptance
// reset: clears the vertices to zero and drops all items in flight
// the receiver takes every result in its cycle and cannot stall the block
module point_triangle_distance #(
    parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptd_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [COORD_WIDTH-1:0]            i_cfg_data,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic signed [COORD_WIDTH-1:0]     i_point_x,
    input  logic signed [COORD_WIDTH-1:0]     i_point_y,
    output logic                              o_done,
    output logic [COORD_WIDTH:0]              o_distance_out
);

    localparam int S  = 2 * COORD_WIDTH + 3;
    localparam int NW = 2 * S;

    logic signed [COORD_WIDTH-1:0] r_ax;
    logic signed [COORD_WIDTH-1:0] r_ay;
    logic signed [COORD_WIDTH-1:0] r_bx;
    logic signed [COORD_WIDTH-1:0] r_by;
    logic signed [COORD_WIDTH-1:0] r_cx;
    logic signed [COORD_WIDTH-1:0] r_cy;

    logic                f_valid;
    logic signed [S-1:0] f_cross [3];
    logic signed [S-1:0] f_dot   [3];
    logic signed [S-1:0] f_len2  [3];
    logic signed [S-1:0] f_vsq   [3];
    logic signed [S-1:0] f_refc;

    ptd_pkg::t_sel_ctl   s_ctl;
    logic [NW-1:0]       s_num;
    logic [S-1:0]        s_den;
    logic [S-1:0]        s_alt;

    logic                d_valid;
    logic [S-1:0]        d_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_bx <= '0;
            r_by <= '0;
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ptd_pkg::REG_A_X: r_ax <= $signed(i_cfg_data);
                ptd_pkg::REG_A_Y: r_ay <= $signed(i_cfg_data);
                ptd_pkg::REG_B_X: r_bx <= $signed(i_cfg_data);
                ptd_pkg::REG_B_Y: r_by <= $signed(i_cfg_data);
                ptd_pkg::REG_C_X: r_cx <= $signed(i_cfg_data);
                ptd_pkg::REG_C_Y: r_cy <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign o_busy = 1'b0;

    ptd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_px    (i_point_x),
        .i_py    (i_point_y),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_bx    (r_bx),
        .i_by    (r_by),
        .i_cx    (r_cx),
        .i_cy    (r_cy),
        .o_valid (f_valid),
        .o_cross (f_cross),
        .o_dot   (f_dot),
        .o_len2  (f_len2),
        .o_vsq   (f_vsq),
        .o_refc  (f_refc)
    );

    ptd_select #(.COORD_WIDTH(COORD_WIDTH)) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_cross (f_cross),
        .i_dot   (f_dot),
        .i_len2  (f_len2),
        .i_vsq   (f_vsq),
        .i_refc  (f_refc),
        .o_ctl   (s_ctl),
        .o_num   (s_num),
        .o_den   (s_den),
        .o_alt   (s_alt)
    );

    ptd_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_ctl),
        .i_num   (s_num),
        .i_den   (s_den),
        .i_alt   (s_alt),
        .o_valid (d_valid),
        .o_x     (d_x)
    );

    ptd_sqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_x     (d_x),
        .o_valid (o_done),
        .o_root  (o_distance_out)
    );

endmodule

/* sv/ptd_front.sv */
module ptd_front #(
    parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [COORD_WIDTH-1:0]  i_px,
    input  logic signed [COORD_WIDTH-1:0]  i_py,
    input  logic signed [COORD_WIDTH-1:0]  i_ax,
    input  logic signed [COORD_WIDTH-1:0]  i_ay,
    input  logic signed [COORD_WIDTH-1:0]  i_bx,
    input  logic signed [COORD_WIDTH-1:0]  i_by,
    input  logic signed [COORD_WIDTH-1:0]  i_cx,
    input  logic signed [COORD_WIDTH-1:0]  i_cy,
    output logic                           o_valid,
    output logic signed [2*COORD_WIDTH+2:0] o_cross [3],
    output logic signed [2*COORD_WIDTH+2:0] o_dot   [3],
    output logic signed [2*COORD_WIDTH+2:0] o_len2  [3],
    output logic signed [2*COORD_WIDTH+2:0] o_vsq   [3],
    output logic signed [2*COORD_WIDTH+2:0] o_refc
);

    localparam int D = COORD_WIDTH + 1;
    localparam int P = 2 * D;
    localparam int S = 2 * D + 1;

    logic signed [D-1:0] vx [3];
    logic signed [D-1:0] vy [3];
    logic signed [D-1:0] px;
    logic signed [D-1:0] py;
    logic signed [D-1:0] n1_qx [3];
    logic signed [D-1:0] n1_qy [3];
    logic signed [D-1:0] n1_ex [3];
    logic signed [D-1:0] n1_ey [3];

    logic                r1_v;
    logic signed [D-1:0] r1_qx [3];
    logic signed [D-1:0] r1_qy [3];
    logic signed [D-1:0] r1_ex [3];
    logic signed [D-1:0] r1_ey [3];

    logic                r2_v;
    logic signed [P-1:0] r2_cqa [3];
    logic signed [P-1:0] r2_cqb [3];
    logic signed [P-1:0] r2_da  [3];
    logic signed [P-1:0] r2_db  [3];
    logic signed [P-1:0] r2_la  [3];
    logic signed [P-1:0] r2_lb  [3];
    logic signed [P-1:0] r2_sa  [3];
    logic signed [P-1:0] r2_sb  [3];
    logic signed [P-1:0] r2_ra;
    logic signed [P-1:0] r2_rb;

    logic                r3_v;
    logic signed [S-1:0] r3_cross [3];
    logic signed [S-1:0] r3_dot   [3];
    logic signed [S-1:0] r3_len2  [3];
    logic signed [S-1:0] r3_vsq   [3];
    logic signed [S-1:0] r3_refc;

    always_comb begin
        vx[0] = $signed({i_ax[COORD_WIDTH-1], i_ax});
        vy[0] = $signed({i_ay[COORD_WIDTH-1], i_ay});
        vx[1] = $signed({i_bx[COORD_WIDTH-1], i_bx});
        vy[1] = $signed({i_by[COORD_WIDTH-1], i_by});
        vx[2] = $signed({i_cx[COORD_WIDTH-1], i_cx});
        vy[2] = $signed({i_cy[COORD_WIDTH-1], i_cy});
        px    = $signed({i_px[COORD_WIDTH-1], i_px});
        py    = $signed({i_py[COORD_WIDTH-1], i_py});
        for (int i = 0; i < 3; i++) begin
            n1_qx[i] = px - vx[i];
            n1_qy[i] = py - vy[i];
            n1_ex[i] = vx[(i+1)%3] - vx[i];
            n1_ey[i] = vy[(i+1)%3] - vy[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_qx[i] <= n1_qx[i];
            r1_qy[i] <= n1_qy[i];
            r1_ex[i] <= n1_ex[i];
            r1_ey[i] <= n1_ey[i];

            r2_cqa[i] <= r1_ex[i] * r1_qy[i];
            r2_cqb[i] <= r1_ey[i] * r1_qx[i];
            r2_da[i]  <= r1_qx[i] * r1_ex[i];
            r2_db[i]  <= r1_qy[i] * r1_ey[i];
            r2_la[i]  <= r1_ex[i] * r1_ex[i];
            r2_lb[i]  <= r1_ey[i] * r1_ey[i];
            r2_sa[i]  <= r1_qx[i] * r1_qx[i];
            r2_sb[i]  <= r1_qy[i] * r1_qy[i];

            r3_cross[i] <= S'(r2_cqa[i]) - S'(r2_cqb[i]);
            r3_dot[i]   <= S'(r2_da[i]) + S'(r2_db[i]);
            r3_len2[i]  <= S'(r2_la[i]) + S'(r2_lb[i]);
            r3_vsq[i]   <= S'(r2_sa[i]) + S'(r2_sb[i]);
        end
        // side of b against edge ca
        r2_ra   <= r1_ey[2] * r1_ex[1];
        r2_rb   <= r1_ex[2] * r1_ey[1];
        r3_refc <= S'(r2_ra) - S'(r2_rb);
    end

    assign o_valid = r3_v;
    assign o_cross = r3_cross;
    assign o_dot   = r3_dot;
    assign o_len2  = r3_len2;
    assign o_vsq   = r3_vsq;
    assign o_refc  = r3_refc;

endmodule

/* sv/ptd_select.sv */
module ptd_select #(
    parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [2*COORD_WIDTH+2:0] i_cross [3],
    input  logic signed [2*COORD_WIDTH+2:0] i_dot   [3],
    input  logic signed [2*COORD_WIDTH+2:0] i_len2  [3],
    input  logic signed [2*COORD_WIDTH+2:0] i_vsq   [3],
    input  logic signed [2*COORD_WIDTH+2:0] i_refc,
    output ptd_pkg::t_sel_ctl               o_ctl,
    output logic [4*COORD_WIDTH+5:0]        o_num,
    output logic [2*COORD_WIDTH+2:0]        o_den,
    output logic [2*COORD_WIDTH+2:0]        o_alt
);

    localparam int S  = 2 * COORD_WIDTH + 3;
    localparam int NW = 2 * S;
    localparam int QL = (S + 1) / 2;
    localparam int QH = S - QL;

    logic [2:0]          match;
    logic [1:0]          nfail;
    logic [1:0]          bad;
    logic signed [S-1:0] c_sel;
    logic signed [S-1:0] d_sel;
    logic signed [S-1:0] l_sel;
    logic signed [S-1:0] m01;
    logic signed [S-1:0] m012;
    logic                seg;
    ptd_pkg::t_sel_ctl   n4_ctl;
    logic [S-1:0]        n4_q;
    logic [S-1:0]        n4_alt;

    ptd_pkg::t_sel_ctl   r4_ctl;
    logic [S-1:0]        r4_q;
    logic [S-1:0]        r4_den;
    logic [S-1:0]        r4_alt;

    ptd_pkg::t_sel_ctl   r5_ctl;
    logic [2*QL-1:0]     r5_ll;
    logic [QL+QH-1:0]    r5_lh;
    logic [2*QH-1:0]     r5_hh;
    logic [S-1:0]        r5_den;
    logic [S-1:0]        r5_alt;

    ptd_pkg::t_sel_ctl   r6_ctl;
    logic [NW-1:0]       r6_num;
    logic [S-1:0]        r6_den;
    logic [S-1:0]        r6_alt;

    always_comb begin
        bad = 2'd0;
        for (int i = 0; i < 3; i++) begin
            match[i] = (i_cross[i][S-1] == i_refc[S-1]) &&
                       ((i_cross[i] == '0) == (i_refc == '0));
            if (!match[i]) begin
                bad = 2'(i);
            end
        end
        nfail = 2'(!match[0]) + 2'(!match[1]) + 2'(!match[2]);

        unique case (bad)
            2'd1: begin
                c_sel = i_cross[1];
                d_sel = i_dot[1];
                l_sel = i_len2[1];
            end
            2'd2: begin
                c_sel = i_cross[2];
                d_sel = i_dot[2];
                l_sel = i_len2[2];
            end
            default: begin
                c_sel = i_cross[0];
                d_sel = i_dot[0];
                l_sel = i_len2[0];
            end
        endcase

        seg  = (l_sel != '0) && !d_sel[S-1] && (d_sel <= l_sel);
        m01  = (i_vsq[1] < i_vsq[0]) ? i_vsq[1] : i_vsq[0];
        m012 = (i_vsq[2] < m01) ? i_vsq[2] : m01;

        n4_ctl.valid   = i_valid;
        n4_ctl.use_div = (nfail == 2'd1) && seg;
        n4_q           = c_sel[S-1] ? $unsigned(-c_sel) : $unsigned(c_sel);
        n4_alt         = (nfail == 2'd0) ? '0 : $unsigned(m012);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_ctl <= '0;
            r5_ctl <= '0;
            r6_ctl <= '0;
        end else begin
            r4_ctl <= n4_ctl;
            r5_ctl <= r4_ctl;
            r6_ctl <= r5_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_q   <= n4_q;
        r4_den <= $unsigned(l_sel);
        r4_alt <= n4_alt;

        // square of the cross product in partial products
        r5_ll  <= r4_q[QL-1:0] * r4_q[QL-1:0];
        r5_lh  <= r4_q[QL-1:0] * r4_q[S-1:QL];
        r5_hh  <= r4_q[S-1:QL] * r4_q[S-1:QL];
        r5_den <= r4_den;
        r5_alt <= r4_alt;

        r6_num <= (NW'(r5_hh) << (2*QL)) + (NW'(r5_lh) << (QL+1)) + NW'(r5_ll);
        r6_den <= r5_den;
        r6_alt <= r5_alt;
    end

    assign o_ctl = r6_ctl;
    assign o_num = r6_num;
    assign o_den = r6_den;
    assign o_alt = r6_alt;

endmodule

/* sv/ptd_div.sv */
module ptd_div #(
    parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ptd_pkg::t_sel_ctl         i_ctl,
    input  logic [4*COORD_WIDTH+5:0]  i_num,
    input  logic [2*COORD_WIDTH+2:0]  i_den,
    input  logic [2*COORD_WIDTH+2:0]  i_alt,
    output logic                      o_valid,
    output logic [2*COORD_WIDTH+2:0]  o_x
);

    localparam int S  = 2 * COORD_WIDTH + 3;
    localparam int NW = 2 * S;

    ptd_pkg::t_sel_ctl r_ctl [S+1];
    logic              r_sat [S+1];
    logic [NW-1:0]     r_rem [S+1];
    logic [S-1:0]      r_quo [S+1];
    logic [S-1:0]      r_den [S+1];
    logic [S-1:0]      r_alt [S+1];

    // quotient too large for the root range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0] <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat[0] <= (i_num >= {i_den, {S{1'b0}}});
        r_rem[0] <= i_num;
        r_quo[0] <= '0;
        r_den[0] <= i_den;
        r_alt[0] <= i_alt;
    end

    for (genvar j = 0; j < S; j++) begin : g_stage
        localparam int K = S - 1 - j;

        logic [NW-1:0] dsh;
        logic          ge;
        logic [NW-1:0] n_rem;
        logic [S-1:0]  n_quo;

        always_comb begin
            dsh   = NW'(r_den[j]) << K;
            ge    = (r_rem[j] >= dsh);
            n_rem = ge ? (r_rem[j] - dsh) : r_rem[j];
            n_quo = r_quo[j];
            n_quo[K] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j+1] <= '0;
            end else begin
                r_ctl[j+1] <= r_ctl[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sat[j+1] <= r_sat[j];
            r_rem[j+1] <= n_rem;
            r_quo[j+1] <= n_quo;
            r_den[j+1] <= r_den[j];
            r_alt[j+1] <= r_alt[j];
        end
    end

    assign o_valid = r_ctl[S].valid;
    assign o_x     = !r_ctl[S].use_div ? r_alt[S] :
                     (r_sat[S] ? {S{1'b1}} : r_quo[S]);

endmodule

/* sv/ptd_sqrt.sv */
module ptd_sqrt #(
    parameter int COORD_WIDTH = ptd_pkg::COORD_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [2*COORD_WIDTH+2:0]  i_x,
    output logic                      o_valid,
    output logic [COORD_WIDTH:0]      o_root
);

    localparam int XW = 2 * COORD_WIDTH + 3;
    localparam int RW = COORD_WIDTH + 2;
    localparam int SW = 2 * RW + 1;

    logic          r_v  [RW];
    logic [RW-1:0] r_d  [RW];
    logic [SW-1:0] r_sq [RW];
    logic [XW-1:0] r_x  [RW];
    logic          r_ov;
    logic [COORD_WIDTH:0] r_root;

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int B = RW - 1 - j;

        logic          p_v;
        logic [RW-1:0] p_d;
        logic [SW-1:0] p_sq;
        logic [XW-1:0] p_x;
        logic [SW-1:0] trial;
        logic          take;
        logic [RW-1:0] n_d;

        if (j == 0) begin : g_first
            assign p_v  = i_valid;
            assign p_d  = '0;
            assign p_sq = '0;
            assign p_x  = i_x;
        end else begin : g_rest
            assign p_v  = r_v[j-1];
            assign p_d  = r_d[j-1];
            assign p_sq = r_sq[j-1];
            assign p_x  = r_x[j-1];
        end

        // (d + 2^b)^2 = d^2 + d*2^(b+1) + 2^(2b)
        always_comb begin
            trial = p_sq + (SW'(p_d) << (B+1)) + (SW'(1) << (2*B));
            take  = (trial <= SW'(p_x));
            n_d   = p_d;
            n_d[B] = take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_d[j]  <= n_d;
            r_sq[j] <= take ? trial : p_sq;
            r_x[j]  <= p_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[RW-1];
        end
    end

    // saturate at the top of the output range
    always_ff @(posedge i_clk) begin
        r_root <= r_d[RW-1][RW-1] ? '1 : r_d[RW-1][COORD_WIDTH:0];
    end

    assign o_valid = r_ov;
    assign o_root  = r_root;

endmodule

/* sim/point_triangle_distance_test.sv */
module point_triangle_distance_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int        COORD_WIDTH = ptd_pkg::COORD_WIDTH;
    localparam int        CFG_ADDR_W  = ptd_pkg::CFG_ADDR_W;
    localparam int        LATENCY   = 3 * COORD_WIDTH + 13;
    localparam longint    CYCLE_CAP = 400000;
    localparam int        N_RANDOM  = 1650;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]         i_cfg_addr = ptd_pkg::REG_A_X;
    logic [COORD_WIDTH-1:0]        i_cfg_data = '0;
    logic                          i_start = 1'b0;
    logic                          o_busy;
    logic signed [COORD_WIDTH-1:0] i_point_x = '0;
    logic signed [COORD_WIDTH-1:0] i_point_y = '0;
    logic                          o_done;
    logic [COORD_WIDTH:0]          o_distance_out;

    logic [COORD_WIDTH:0]          dist_expected[$];
    logic signed [COORD_WIDTH-1:0] vertex[6] = '{default: '0};
    int                            mismatches = 0;
    longint                        cycles = 0;
    bit                            idling_on = 1'b1;

    point_triangle_distance dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .o_done         (o_done),
        .o_distance_out (o_distance_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- distance predictor ----------------

    function automatic int side_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint cross_at(longint ox, longint oy, longint ex, longint ey,
                                        longint px, longint py);
        return (ex - ox) * (py - oy) - (ey - oy) * (px - ox);
    endfunction

    // largest d with d*d*scale <= n
    function automatic logic [COORD_WIDTH:0] root_scaled(logic [127:0] n, logic [127:0] scale);
        logic [127:0] d;
        logic [127:0] c;
        d = '0;
        for (int b = COORD_WIDTH; b >= 0; b--) begin
            c = d | (128'd1 << b);
            if (c * c * scale <= n)
                d = c;
        end
        return d[COORD_WIDTH:0];
    endfunction

    function automatic logic [COORD_WIDTH:0] corner_dist(longint vx, longint vy,
                                                         longint px, longint py);
        longint dx;
        longint dy;
        dx = px - vx;
        dy = py - vy;
        return root_scaled(128'(dx * dx + dy * dy), 128'd1);
    endfunction

    function automatic logic [COORD_WIDTH:0] triangle_dist(longint px, longint py);
        longint vx[3];
        longint vy[3];
        longint ex, ey, qx, qy, len2, dot, c, q;
        int ref_side, same, bad, e;
        logic [COORD_WIDTH:0] best, d;
        for (int i = 0; i < 3; i++) begin
            vx[i] = longint'(vertex[2*i]);
            vy[i] = longint'(vertex[2*i+1]);
        end
        ref_side = side_of(cross_at(vx[2], vy[2], vx[0], vy[0], vx[1], vy[1]));
        same = 0;
        bad = 0;
        for (int i = 0; i < 3; i++) begin
            e = (i + 1) % 3;
            if (side_of(cross_at(vx[i], vy[i], vx[e], vy[e], px, py)) == ref_side)
                same++;
            else
                bad = i;
        end
        if (same == 3)
            return '0;
        if (same == 2) begin
            e = (bad + 1) % 3;
            ex = vx[e] - vx[bad];
            ey = vy[e] - vy[bad];
            qx = px - vx[bad];
            qy = py - vy[bad];
            len2 = ex * ex + ey * ey;
            dot = qx * ex + qy * ey;
            if (len2 > 0 && dot >= 0 && dot <= len2) begin
                c = ex * qy - ey * qx;
                q = (c < 0) ? -c : c;
                return root_scaled(128'(q) * 128'(q), 128'(len2));
            end
        end
        best = corner_dist(vx[0], vy[0], px, py);
        for (int i = 1; i < 3; i++) begin
            d = corner_dist(vx[i], vy[i], px, py);
            if (d < best)
                best = d;
        end
        return best;
    endfunction

    // ---------------- checking ----------------

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("point_triangle_distance_test: errors");
            $finish;
        end
        if (i_rst_n && o_done) begin
            if (dist_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: distance %0d", o_distance_out);
            end else begin
                if (o_distance_out !== dist_expected[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("distance mismatch: expected %0d actual %0d",
                                 dist_expected[0], o_distance_out);
                end
                void'(dist_expected.pop_front());
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic send_point(logic signed [COORD_WIDTH-1:0] px,
                              logic signed [COORD_WIDTH-1:0] py);
        while (idling_on && $urandom_range(99) < 33) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        do @(posedge i_clk); while (o_busy);
        dist_expected.push_back(triangle_dist(longint'(px), longint'(py)));
    endtask

    task automatic drain;
        i_start <= 1'b0;
        while (dist_expected.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic set_triangle(int ax, int ay, int bx, int by, int cx, int cy);
        int v[6];
        logic [CFG_ADDR_W-1:0] regs[6];
        v = '{ax, ay, bx, by, cx, cy};
        regs = '{ptd_pkg::REG_A_X, ptd_pkg::REG_A_Y, ptd_pkg::REG_B_X,
                 ptd_pkg::REG_B_Y, ptd_pkg::REG_C_X, ptd_pkg::REG_C_Y};
        drain();
        for (int i = 0; i < 6; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= regs[i];
            i_cfg_data <= v[i][COORD_WIDTH-1:0];
            @(posedge i_clk);
            vertex[i] = v[i][COORD_WIDTH-1:0];
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] clamp16(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] any_coord();
        int unsigned r;
        r = $urandom_range(65535);
        return r[COORD_WIDTH-1:0];
    endfunction

    // ---------------- tests ----------------

    task automatic test_reset_triangle;
        // all vertices at the origin: degenerate, reference side zero
        send_point(16'sh0000, 16'sh0000);
        send_point(16'sh7fff, 16'sh7fff);
        send_point(16'sh8000, 16'sh8000);
        send_point(16'sh8000, 16'sh7fff);
    endtask

    task automatic test_directed;
        // counterclockwise triangle: inside, on edges, at a corner, past each edge
        set_triangle(0, 0, 1600, 0, 0, 1600);
        send_point(100, 100);
        send_point(800, 0);
        send_point(0, 0);
        send_point(800, -500);
        send_point(-500, 800);
        send_point(1000, 1000);
        send_point(-300, -300);
        send_point(2000, -100);
        send_point(16'sh7fff, 16'sh8000);
        // clockwise order
        set_triangle(0, 0, 0, 1600, 1600, 0);
        send_point(100, 100);
        send_point(800, -500);
        send_point(1000, 1000);
        // extreme vertices, saturation
        set_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
        send_point(16'sh7fff, 16'sh7fff);
        send_point(16'sh8000, 16'sh8000);
        send_point(0, 0);
        // collinear and repeated vertices
        set_triangle(-100, -100, 100, 100, 300, 300);
        send_point(0, 0);
        send_point(0, 200);
        set_triangle(500, 500, 500, 500, 900, -200);
        send_point(500, 500);
        send_point(700, 700);
    endtask

    task automatic random_points(int n, int near_pct, int ax, int ay, int bx, int by,
                                 int cx, int cy);
        int vx[3];
        int vy[3];
        int k;
        int r;
        vx = '{ax, bx, cx};
        vy = '{ay, by, cy};
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < near_pct) begin
                k = $urandom_range(2);
                r = 1 << $urandom_range(12);
                send_point(clamp16(vx[k] + $urandom_range(2*r) - r),
                           clamp16(vy[k] + $urandom_range(2*r) - r));
            end else begin
                send_point(any_coord(), any_coord());
            end
        end
    endtask

    task automatic test_random;
        int t[6];
        int span;
        for (int set_ix = 0; set_ix < 11; set_ix++) begin
            span = (set_ix % 3 == 0) ? 32768 : (1 << $urandom_range(14, 6));
            for (int i = 0; i < 6; i++)
                t[i] = $urandom_range(2*span - 1) - span;
            if (set_ix == 5) begin
                t[4] = t[2];
                t[5] = t[3];
            end
            idling_on = (set_ix != 4);
            set_triangle(t[0], t[1], t[2], t[3], t[4], t[5]);
            random_points(N_RANDOM / 11, 80, t[0], t[1], t[2], t[3], t[4], t[5]);
        end
        idling_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_triangle();
        test_directed();
        test_random();
        drain();
        if (mismatches == 0 && dist_expected.size() == 0)
            $display("point_triangle_distance_test: clean");
        else
            $display("point_triangle_distance_test: errors");
        $finish;
    end

endmodule
